### rtl/core/mbd_pkg.sv
// mbd_pkg: shared types and constants of the mipmap 2x2 box downsampler
// pixel and pair-sum layouts, configuration register indexes
// no dependencies
package mbd_pkg;

    localparam int CHAN_W      = 8;
    localparam int PIXEL_W     = 4 * CHAN_W;
    localparam int PAIR_W      = CHAN_W + 1;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int ROW_W       = 8;
    localparam int HEIGHT_LIMIT = 256;
    localparam int DIM_MIN      = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_MODE = 2'd2;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef logic [PAIR_W-1:0] pair_sum_t;

    // four horizontal pair sums, red in the lowest bits
    typedef struct packed {
        pair_sum_t alpha;
        pair_sum_t blue;
        pair_sum_t green;
        pair_sum_t red;
    } pair_t;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

endpackage

### rtl/core/mipmap_box_downsample_core.sv
// mipmap_box_downsample_core: 2x2 box filter producing the next mipmap level
// line buffer of horizontal pair sums in one synchronous memory
// depends on mbd_pkg
//
// channel  | direction | transaction                 | payload
// ---------+-----------+-----------------------------+--------------------------------
// s_axis   | in        | one source pixel, raster    | tdata: red, green, blue, alpha
// m_axis   | out       | one averaged output pixel   | tdata: red, green, blue, alpha;
//          |           |                             | tlast: last pixel of the level
// cfg      | in        | one register write          | cfg_index, cfg_data
//
// one source pixel is taken every clock while the read stage can move; the line buffer
// memory port is used at most once per pixel (write on even rows, read on odd rows),
// which sets that rate; a result goes from its odd-row odd-column pixel through the
// memory read, then the add and shift into the output register
// rst_n clears counters and valid flags; config reset values are 256, 256, rgba
// a stalled m_axis holds the output register; the read stage behind it keeps taking
// pixels until it is full as well
module mipmap_box_downsample_core
    import mbd_pkg::*;
#(
    parameter int MAX_WIDTH = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // source pixel stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIXEL_W-1:0]     s_axis_tdata,   // red, green, blue, alpha from bit 0 up
    // output pixel stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [PIXEL_W-1:0]     m_axis_tdata,   // red, green, blue, alpha from bit 0 up
    output logic                   m_axis_tlast    // last_of_level
);

    // widths that follow from the largest supported row
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ? $clog2(MAX_WIDTH + 1)
                                                             : CFG_DATA_W;
    localparam logic [DW-1:0] MAX_W_V = DW'(MAX_WIDTH);
    localparam logic [DW-1:0] MIN_W_V = DW'(DIM_MIN);
    localparam logic [CFG_DATA_W-1:0] MAX_H_V = CFG_DATA_W'(HEIGHT_LIMIT);
    localparam logic [CFG_DATA_W-1:0] MIN_H_V = CFG_DATA_W'(DIM_MIN);

    // configuration registers
    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;
    logic                  alpha_mode_reg, alpha_mode_next;

    // position counters
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // even-column pixel waiting for its partner
    pixel_t held_reg, held_next;

    // read stage: pixel whose line buffer entry is being read
    logic  s1_valid_reg, s1_valid_next;
    pair_t s1_pair_reg, s1_pair_next;
    logic  s1_last_reg, s1_last_next;

    // output register
    logic   out_valid_reg, out_valid_next;
    pixel_t out_pixel_reg, out_pixel_next;
    logic   out_last_reg, out_last_next;

    // line buffer of pair sums
    pair_t           line_mem [LINE_DEPTH];
    pair_t           rd_data_reg;
    logic            mem_we;
    logic            mem_re;
    logic [IW-1:0]   mem_addr;

    // clamped dimensions and derived limits
    logic [DW-1:0]         w_eff;
    logic [DW-1:0]         w_even;
    logic [DW-1:0]         w_half_last;
    logic [CFG_DATA_W-1:0] h_eff;
    logic [CFG_DATA_W-1:0] h_even;

    logic   accept;
    logic   s1_move;
    logic   in_range;
    logic   col_wrap;
    logic   row_wrap;
    logic   is_last;
    pixel_t px;
    pair_t  pair_new;
    pair_t  total_src;

    // 10-bit total of each channel; its upper eight bits are the sum divided by four
    logic [PAIR_W:0] tot_r, tot_g, tot_b, tot_a;

    always_comb
    begin
        if (width_reg < CFG_DATA_W'(DIM_MIN))
            w_eff = MIN_W_V;
        else if (DW'(width_reg) > MAX_W_V)
            w_eff = MAX_W_V;
        else
            w_eff = DW'(width_reg);

        if (height_reg < MIN_H_V)
            h_eff = MIN_H_V;
        else if (height_reg > MAX_H_V)
            h_eff = MAX_H_V;
        else
            h_eff = height_reg;

        w_even      = {w_eff[DW-1:1], 1'b0};
        w_half_last = DW'(w_eff[DW-1:1]) - DW'(1);
        h_even      = {h_eff[CFG_DATA_W-1:1], 1'b0};
    end

    // handshake: the read stage is the skid buffer in front of the output register
    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign px = pixel_t'(s_axis_tdata);

    // an odd last column or an odd last row gives no result
    assign in_range = (DW'(col_reg) < w_even) && (CFG_DATA_W'(row_reg) < h_even);
    assign col_wrap = (DW'(col_reg) + DW'(1)) >= w_eff;
    assign row_wrap = (CFG_DATA_W'(row_reg) + CFG_DATA_W'(1)) >= h_eff;
    assign is_last  = (DW'(col_reg[CW-1:1]) == w_half_last)
                   && (CFG_DATA_W'(row_reg) == h_even - CFG_DATA_W'(1));

    always_comb
    begin
        pair_new.red   = PAIR_W'(held_reg.red)   + PAIR_W'(px.red);
        pair_new.green = PAIR_W'(held_reg.green) + PAIR_W'(px.green);
        pair_new.blue  = PAIR_W'(held_reg.blue)  + PAIR_W'(px.blue);
        pair_new.alpha = PAIR_W'(held_reg.alpha) + PAIR_W'(px.alpha);
    end

    // even rows store pair sums, odd rows fetch the stored ones
    assign mem_addr = col_reg[IW:1];
    assign mem_we   = accept && in_range && col_reg[0] && !row_reg[0];
    assign mem_re   = accept && in_range && col_reg[0] &&  row_reg[0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_addr] <= pair_new;
        if (mem_re)
            rd_data_reg <= line_mem[mem_addr];
    end

    // second stage: add the two pair sums and drop two bits
    assign total_src = s1_pair_reg;
    assign tot_r = (PAIR_W+1)'(rd_data_reg.red)   + (PAIR_W+1)'(total_src.red);
    assign tot_g = (PAIR_W+1)'(rd_data_reg.green) + (PAIR_W+1)'(total_src.green);
    assign tot_b = (PAIR_W+1)'(rd_data_reg.blue)  + (PAIR_W+1)'(total_src.blue);
    assign tot_a = (PAIR_W+1)'(rd_data_reg.alpha) + (PAIR_W+1)'(total_src.alpha);

    always_comb
    begin
        width_next      = width_reg;
        height_next     = height_reg;
        alpha_mode_next = alpha_mode_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        held_next       = held_reg;
        s1_valid_next   = s1_valid_reg;
        s1_pair_next    = s1_pair_reg;
        s1_last_next    = s1_last_reg;
        out_valid_next  = out_valid_reg;
        out_pixel_next  = out_pixel_reg;
        out_last_next   = out_last_reg;

        // output register
        if (s1_move)
        begin
            out_valid_next       = 1'b1;
            out_pixel_next.red   = tot_r[PAIR_W:2];
            out_pixel_next.green = tot_g[PAIR_W:2];
            out_pixel_next.blue  = tot_b[PAIR_W:2];
            out_pixel_next.alpha = alpha_mode_reg ? tot_a[PAIR_W:2] : ALPHA_OPAQUE;
            out_last_next        = s1_last_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // read stage
        if (s1_move)
            s1_valid_next = 1'b0;
        if (mem_re)
        begin
            s1_valid_next = 1'b1;
            s1_pair_next  = pair_new;
            s1_last_next  = is_last;
        end

        // position and held pixel
        if (accept)
        begin
            if (!col_reg[0])
                held_next = px;
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end

        // configuration writes; the user must write only while idle, the block does not enforce it
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:
                begin
                    width_next = cfg_data;
                    col_next   = '0;
                    row_next   = '0;
                end
                REG_SRC_HEIGHT:
                begin
                    height_next = cfg_data;
                    col_next    = '0;
                    row_next    = '0;
                end
                REG_ALPHA_MODE:
                begin
                    alpha_mode_next = cfg_data[0];
                end
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= CFG_DATA_W'(256);
            height_reg     <= CFG_DATA_W'(256);
            alpha_mode_reg <= 1'b1;
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            alpha_mode_reg <= alpha_mode_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        s1_pair_reg   <= s1_pair_next;
        s1_last_reg   <= s1_last_next;
        out_pixel_reg <= out_pixel_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench of mipmap_box_downsample_core, the 2x2 box-filter mipmap stage
// drives source pixels on s_axis, mirrors the filter in a local predictor and checks m_axis
// depends on mbd_pkg and the core
module tb;
    import mbd_pkg::*;

    localparam int MAX_WIDTH     = 256;
    localparam int LINE_DEPTH    = MAX_WIDTH / 2;
    localparam int ITEM_TARGET   = 1900;
    localparam int BUSY_PCT      = 37;
    localparam int SETTLE_CYCLES = 8;      // result leaves after the read stage and the output register
    localparam int DRAIN_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_GAP       = 20;

    // index with no register behind it, writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        pixel_t px;
        logic   last;
    } out_pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_SRC_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIXEL_W-1:0]     s_axis_tdata = '0;    // red, green, blue, alpha from bit 0 up
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [PIXEL_W-1:0]     m_axis_tdata;         // red, green, blue, alpha from bit 0 up
    logic                   m_axis_tlast;         // last_of_level

    // predictor state, kept in step with the block's registers
    logic [CFG_DATA_W-1:0]  mirror_width = 9'd256;
    logic [CFG_DATA_W-1:0]  mirror_height = 9'd256;
    logic                   mirror_rgba = 1'b1;
    int unsigned            col_pos = 0;
    int unsigned            row_pos = 0;
    pixel_t                 held_px = '0;
    pair_t                  pair_line [LINE_DEPTH];

    out_pixel_t             due_pixels [$];
    int unsigned            pixels_sent = 0;
    int unsigned            mismatches = 0;
    int unsigned            src_idle_pct = BUSY_PCT;
    int unsigned            sink_idle_pct = BUSY_PCT;
    int unsigned            hold_request = 0;
    int unsigned            hold_left = 0;

    mipmap_box_downsample_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // hard stop if the run hangs
    initial
    begin
        #6_000_000;
        $display("tb failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < DIM_MIN)
            return DIM_MIN;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // truncating mean of the four pixels held in two pair sums
    function automatic logic [CHAN_W-1:0] avg4(input pair_sum_t a, input pair_sum_t b);
        logic [PAIR_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[PAIR_W:2];
    endfunction

    // steps the local filter by one accepted source pixel, queues any output pixel
    function automatic void box_filter_predict(input pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned out_w;
        int unsigned out_h;
        int unsigned idx;
        pair_t       pair;
        pair_t       prev;
        out_pixel_t  res;
        w = clamp_dim(mirror_width, MAX_WIDTH);
        h = clamp_dim(mirror_height, HEIGHT_LIMIT);
        out_w = w / 2;
        out_h = h / 2;
        // odd last column and odd last row fall outside this window
        if (col_pos < 2 * out_w && row_pos < 2 * out_h)
        begin
            if (col_pos % 2 == 0)
                held_px = px;
            else
            begin
                idx = (col_pos / 2) % LINE_DEPTH;
                pair.red   = {1'b0, held_px.red}   + {1'b0, px.red};
                pair.green = {1'b0, held_px.green} + {1'b0, px.green};
                pair.blue  = {1'b0, held_px.blue}  + {1'b0, px.blue};
                pair.alpha = {1'b0, held_px.alpha} + {1'b0, px.alpha};
                if (row_pos % 2 == 0)
                    pair_line[idx] = pair;
                else
                begin
                    prev = pair_line[idx];
                    res.px.red   = avg4(prev.red, pair.red);
                    res.px.green = avg4(prev.green, pair.green);
                    res.px.blue  = avg4(prev.blue, pair.blue);
                    res.px.alpha = mirror_rgba ? avg4(prev.alpha, pair.alpha) : ALPHA_OPAQUE;
                    res.last = (col_pos / 2 == out_w - 1) && (row_pos == 2 * out_h - 1);
                    due_pixels.push_back(res);
                end
            end
        end
        // raster advance, wrapping to a new level after the last source pixel
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endfunction

    // ---------------------------------------------------------------- output side

    // receiver: random back-pressure, plus a long hold when a test asks for one
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic void compare_field(input string field, input int unsigned due,
                                          input int unsigned got);
        if (due != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, due, got);
            mismatches++;
        end
    endfunction

    // every output transaction against the oldest predicted pixel
    always @(posedge clk)
    begin
        out_pixel_t due;
        pixel_t     got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (due_pixels.size() == 0)
            begin
                $display("%0t: unexpected output pixel, expected none actual %h last %b",
                         $time, got, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                due = due_pixels.pop_front();
                compare_field("red", due.px.red, got.red);
                compare_field("green", due.px.green, got.green);
                compare_field("blue", due.px.blue, got.blue);
                compare_field("alpha", due.px.alpha, got.alpha);
                compare_field("last_of_level", due.last, m_axis_tlast);
            end
        end
    end

    // ---------------------------------------------------------------- input side

    // one source pixel transaction, entered and left at a falling edge
    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        box_filter_predict(px);
        pixels_sent++;
        @(negedge clk);
    endtask

    // random pixel, with channels pushed to the rails now and then
    function automatic pixel_t rand_pixel();
        pixel_t px;
        px = pixel_t'($urandom);
        if ($urandom_range(3) == 0)
        begin
            if ($urandom_range(1)) px.red = $urandom_range(1) ? 8'hFF : 8'h00;
            if ($urandom_range(1)) px.green = $urandom_range(1) ? 8'hFF : 8'h00;
            if ($urandom_range(1)) px.blue = $urandom_range(1) ? 8'hFF : 8'h00;
            if ($urandom_range(1)) px.alpha = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return px;
    endfunction

    task automatic send_pixels(input int unsigned n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    // stop offering, let every predicted pixel arrive, then let the pipe settle
    task automatic wait_for_results();
        int unsigned waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (due_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write, block idle; the predictor follows the same rules
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SRC_WIDTH:
            begin
                mirror_width = val;
                col_pos = 0;
                row_pos = 0;
            end
            REG_SRC_HEIGHT:
            begin
                mirror_height = val;
                col_pos = 0;
                row_pos = 0;
            end
            REG_ALPHA_MODE:
                mirror_rgba = val[0];
            default:
                ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // alpha mode goes in with junk in the unused upper bits
    task automatic set_level(input int unsigned w, input int unsigned h, input logic rgba);
        write_reg(REG_SRC_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(REG_SRC_HEIGHT, h[CFG_DATA_W-1:0]);
        write_reg(REG_ALPHA_MODE, {8'($urandom), rgba});
    endtask

    // ---------------------------------------------------------------- tests

    // reset values: 256 wide, alpha averaged; two source rows give one output row
    task automatic test_reset_defaults();
        send_pixels(2 * 256);
        wait_for_results();
    endtask

    // rails, truncation of the mean, rgb mode, odd last column and row
    task automatic test_extreme_values();
        set_level(2, 2, 1'b1);
        repeat (4) send_pixel('0);
        repeat (4) send_pixel('1);
        // sums 1019, 3, 510 and 3 all need truncating
        send_pixel('{alpha: 8'd3, blue: 8'd0,   green: 8'd1, red: 8'd255});
        send_pixel('{alpha: 8'd0, blue: 8'd255, green: 8'd1, red: 8'd255});
        send_pixel('{alpha: 8'd0, blue: 8'd0,   green: 8'd1, red: 8'd255});
        send_pixel('{alpha: 8'd0, blue: 8'd255, green: 8'd0, red: 8'd254});
        wait_for_results();
        write_reg(REG_ALPHA_MODE, '0);
        send_pixels(4);
        wait_for_results();
        // 3x3: the third column and third row must give nothing
        set_level(3, 3, 1'b1);
        send_pixels(9);
        wait_for_results();
    endtask

    // out-of-range sizes clamp to the legal window; small levels wrap back to back
    task automatic test_clamped_dimensions();
        set_level(0, 1, 1'b1);
        send_pixels(8);
        wait_for_results();
        set_level(1, 0, 1'b0);
        send_pixels(4);
        wait_for_results();
        set_level(511, 511, 1'b1);
        send_pixels(2 * MAX_WIDTH);
        wait_for_results();
    endtask

    // alpha mode and unused index written mid-level must not restart the raster
    task automatic test_settings_kept();
        set_level(4, 4, 1'b1);
        send_pixels(6);
        wait_for_results();
        write_reg(REG_ALPHA_MODE, {8'hFF, 1'b0});
        write_reg(REG_UNUSED, '1);
        send_pixels(10);
        wait_for_results();
    endtask

    // a size write, even of the same value, starts the level again
    task automatic test_dimension_restart();
        set_level(4, 4, 1'b1);
        send_pixels(6);
        wait_for_results();
        write_reg(REG_SRC_WIDTH, 9'd4);
        send_pixels(16);
        wait_for_results();
        send_pixels(7);
        wait_for_results();
        write_reg(REG_SRC_HEIGHT, 9'd4);
        send_pixels(16);
        wait_for_results();
    endtask

    // receiver holds off for a long stretch while pixels keep coming, so the core stalls s_axis
    task automatic test_output_stall();
        set_level(6, 8, 1'b1);
        hold_request = HOLD_CYCLES;
        send_pixels(48);
        wait_for_results();
    endtask

    // sender stops mid-level until every output pixel is out, then carries on
    task automatic test_sender_pause();
        set_level(8, 6, 1'b0);
        send_pixels(20);
        wait_for_results();
        send_pixels(28);
        wait_for_results();
    endtask

    // random levels, mostly complete and sometimes wrapped, some cut short
    task automatic test_random_levels();
        int unsigned lvl;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        lvl = 0;
        while (pixels_sent < ITEM_TARGET)
        begin
            // a few levels in a row with neither side idling
            if (lvl == 3)
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            else if (lvl == 7)
            begin
                src_idle_pct = BUSY_PCT;
                sink_idle_pct = BUSY_PCT;
            end
            w = $urandom_range(16, 2);
            h = $urandom_range(10, 2);
            if (lvl % 5 == 2)
            begin
                w = $urandom_range(64, 17);
                h = $urandom_range(4, 2);
            end
            if (lvl % 11 == 9)
                w = $urandom_range(1, 0);
            if (lvl % 13 == 6)
                h = $urandom_range(1, 0);
            set_level(w, h, 1'($urandom_range(1)));
            n = clamp_dim(w, MAX_WIDTH) * clamp_dim(h, HEIGHT_LIMIT);
            if ($urandom_range(7) == 0)
                n = $urandom_range(n - 1, 1);
            else
                n = n * $urandom_range(2, 1);
            send_pixels(n);
            wait_for_results();
            lvl++;
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_extreme_values();
        test_clamped_dimensions();
        test_settings_kept();
        test_dimension_restart();
        test_output_stall();
        test_sender_pause();
        test_random_levels();
        wait_for_results();
        if (due_pixels.size() != 0)
        begin
            $display("%0t: output pixels missing, expected %0d more actual 0",
                     $time, due_pixels.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
